FILE: sv/cfir_pkg.sv
// Shared types and constants for the complex FIR filter.
`timescale 1ns / 1ps

package cfir_pkg;

  // Default sizes, handed to the top-level parameters.
  localparam int TAPS_DEF        = 16;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int ACC_BITS_DEF    = 40;

  // Item kind carried on in_tuser.
  typedef enum logic {
    CMD_LOAD   = 1'b0,
    CMD_SAMPLE = 1'b1
  } cmd_t;

  // Per-cell control strobes.
  typedef struct packed {
    logic shift;  // advance the delay line by one sample
    logic load;   // write this cell's coefficient
    logic adv;    // pipeline advance: capture the product
  } cell_ctl_t;

endpackage

FILE: sv/cfir_cell.sv
// One filter tap: delay-line stage, coefficient register and complex multiply.
`timescale 1ns / 1ps

module cfir_cell #(
  parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  cfir_pkg::cell_ctl_t             ctl_i,
  input  logic signed [SAMPLE_BITS-1:0]   din_re,
  input  logic signed [SAMPLE_BITS-1:0]   din_im,
  input  logic signed [SAMPLE_BITS-1:0]   coef_re,
  input  logic signed [SAMPLE_BITS-1:0]   coef_im,
  output logic signed [SAMPLE_BITS-1:0]   dout_re,
  output logic signed [SAMPLE_BITS-1:0]   dout_im,
  output logic signed [2*SAMPLE_BITS:0]   prod_re,
  output logic signed [2*SAMPLE_BITS:0]   prod_im
);

  localparam int MUL_W  = 2 * SAMPLE_BITS;
  localparam int PROD_W = MUL_W + 1;

  logic signed [SAMPLE_BITS-1:0] d_re_r, d_im_r;
  logic signed [SAMPLE_BITS-1:0] c_re_r, c_im_r;
  logic signed [MUL_W-1:0]       m_rr, m_ii, m_ri, m_ir;
  logic signed [PROD_W-1:0]      pr_re_r, pr_im_r, pr_re_nxt, pr_im_nxt;

  // Delay stage: cleared by reset, shifts on each accepted sample.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_re_r <= '0;
      d_im_r <= '0;
    end else if (ctl_i.shift) begin
      d_re_r <= din_re;
      d_im_r <= din_im;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_i.load) begin
      c_re_r <= coef_re;
      c_im_r <= coef_im;
    end
  end

  always_comb begin
    m_rr      = d_re_r * c_re_r;
    m_ii      = d_im_r * c_im_r;
    m_ri      = d_re_r * c_im_r;
    m_ir      = c_re_r * d_im_r;
    pr_re_nxt = {m_rr[MUL_W-1], m_rr} - {m_ii[MUL_W-1], m_ii};
    pr_im_nxt = {m_ri[MUL_W-1], m_ri} + {m_ir[MUL_W-1], m_ir};
  end

  always_ff @(posedge clk) begin
    if (ctl_i.adv) begin
      pr_re_r <= pr_re_nxt;
      pr_im_r <= pr_im_nxt;
    end
  end

  assign dout_re = d_re_r;
  assign dout_im = d_im_r;
  assign prod_re = pr_re_r;
  assign prod_im = pr_im_r;

endmodule

FILE: sv/cfir_add_tree.sv
// Registered binary adder tree that sums the tap products; each level is registered and advances on en.
`timescale 1ns / 1ps

module cfir_add_tree #(
  parameter int LEAVES = cfir_pkg::TAPS_DEF,
  parameter int W      = cfir_pkg::ACC_BITS_DEF
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] leaf_i [LEAVES],
  output logic [W-1:0] root_o
);

  localparam int LVLS = $clog2(LEAVES);
  localparam int P    = 2 ** LVLS;

  logic [W-1:0] leaf   [P];
  logic [W-1:0] node_r [P-1];

  // Pad unused leaves with zero.
  for (genvar g = 0; g < P; g++) begin : g_leaf
    if (g < LEAVES) begin : g_used
      assign leaf[g] = leaf_i[g];
    end else begin : g_pad
      assign leaf[g] = '0;
    end
  end

  // Heap order: node n has children 2n+1 and 2n+2; the last P entries are leaves.
  for (genvar n = 0; n < P - 1; n++) begin : g_node
    localparam int CL = 2 * n + 1;
    localparam int CR = 2 * n + 2;
    logic [W-1:0] lhs, rhs;

    if (CL < P - 1) begin : g_lint
      assign lhs = node_r[CL];
    end else begin : g_lleaf
      assign lhs = leaf[CL-(P-1)];
    end

    if (CR < P - 1) begin : g_rint
      assign rhs = node_r[CR];
    end else begin : g_rleaf
      assign rhs = leaf[CR-(P-1)];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        node_r[n] <= lhs + rhs;
      end
    end
  end

  assign root_o = node_r[0];

endmodule

FILE: sv/complex_fir_filter.sv
// Top level of the complex FIR filter: tap cell chain, adder trees, stream control.
`timescale 1ns / 1ps
//
//  Channel | Direction | Handshake               | Payload
//  --------+-----------+-------------------------+--------------------------------------
//  in_     | slave     | in_tvalid / in_tready   | tuser: cmd; tdata: tap_index,
//          |           |                         |   value_real, value_imag (zero pad)
//  out_    | master    | out_tvalid / out_tready | tdata: out_real, out_imag (zero pad)
//
//  One item is accepted per clock while the output side keeps up.
//  A sample's result passes through registers in this order: the transfer edge itself
//  shifts the delay line, then the per-tap complex multiply register captures the product,
//  then one register per adder-tree level; the tree depth sets the latency.
//  Reset clears the delay line and the result pipeline; coefficients are not cleared.
//  A result held on the output freezes the whole pipeline and drops in_tready.
//
module complex_fir_filter #(
  parameter int TAPS        = cfir_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = cfir_pkg::ACC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // tap_index, value_real, value_imag from bit 0 up, zero pad to bytes
  input  logic [((($clog2(TAPS)+2*SAMPLE_BITS)+7)/8)*8-1:0] in_tdata,
  // cmd
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // out_real, out_imag from bit 0 up, zero pad to bytes
  output logic [((2*ACC_BITS+7)/8)*8-1:0]       out_tdata
);

  localparam int IDX_W  = $clog2(TAPS);
  localparam int OUT_W  = ((2 * ACC_BITS + 7) / 8) * 8;
  localparam int LVLS   = $clog2(TAPS);
  localparam int LAT    = LVLS + 2;
  localparam int PROD_W = 2 * SAMPLE_BITS + 1;

  logic [IDX_W-1:0]              in_tap_index;
  logic signed [SAMPLE_BITS-1:0] in_value_real, in_value_imag;
  logic                          adv, in_fire, smp_fire, ld_fire;
  logic [LAT-1:0]                vld_r;

  logic signed [SAMPLE_BITS-1:0] dly_re [TAPS];
  logic signed [SAMPLE_BITS-1:0] dly_im [TAPS];
  logic signed [PROD_W-1:0]      prd_re [TAPS];
  logic signed [PROD_W-1:0]      prd_im [TAPS];
  logic [ACC_BITS-1:0]           leaf_re [TAPS];
  logic [ACC_BITS-1:0]           leaf_im [TAPS];
  logic [ACC_BITS-1:0]           sum_re, sum_im;

  // Unpack the input transfer.
  assign in_tap_index  = in_tdata[IDX_W-1:0];
  assign in_value_real = in_tdata[IDX_W+SAMPLE_BITS-1:IDX_W];
  assign in_value_imag = in_tdata[IDX_W+2*SAMPLE_BITS-1:IDX_W+SAMPLE_BITS];

  // The whole pipeline moves together; it holds only while a result waits.
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign in_fire   = in_tvalid && in_tready;
  assign smp_fire  = in_fire && (in_tuser == cfir_pkg::CMD_SAMPLE);
  assign ld_fire   = in_fire && (in_tuser == cfir_pkg::CMD_LOAD);

  // Valid marks follow each sample through shift, multiply and tree levels.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], smp_fire};
    end
  end

  assign out_tvalid = vld_r[LAT-1];

  // Tap cells: the sample enters cell 0 and moves one cell per accepted sample.
  for (genvar t = 0; t < TAPS; t++) begin : g_tap
    cfir_pkg::cell_ctl_t           ctl;
    logic signed [SAMPLE_BITS-1:0] din_re, din_im;

    assign ctl.shift = smp_fire;
    assign ctl.load  = ld_fire && (in_tap_index == IDX_W'(t));
    assign ctl.adv   = adv;

    if (t == 0) begin : g_head
      assign din_re = in_value_real;
      assign din_im = in_value_imag;
    end else begin : g_body
      assign din_re = dly_re[t-1];
      assign din_im = dly_im[t-1];
    end

    cfir_cell #(
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl_i   (ctl),
      .din_re  (din_re),
      .din_im  (din_im),
      .coef_re (in_value_real),
      .coef_im (in_value_imag),
      .dout_re (dly_re[t]),
      .dout_im (dly_im[t]),
      .prod_re (prd_re[t]),
      .prod_im (prd_im[t])
    );

    // Sign-extend or wrap each product to the accumulator width.
    assign leaf_re[t] = ACC_BITS'(prd_re[t]);
    assign leaf_im[t] = ACC_BITS'(prd_im[t]);
  end

  cfir_add_tree #(
    .LEAVES (TAPS),
    .W      (ACC_BITS)
  ) u_tree_re (
    .clk    (clk),
    .en     (adv),
    .leaf_i (leaf_re),
    .root_o (sum_re)
  );

  cfir_add_tree #(
    .LEAVES (TAPS),
    .W      (ACC_BITS)
  ) u_tree_im (
    .clk    (clk),
    .en     (adv),
    .leaf_i (leaf_im),
    .root_o (sum_im)
  );

  // The tree roots are the output register.
  if (OUT_W > 2 * ACC_BITS) begin : g_out_pad
    assign out_tdata = {{(OUT_W - 2 * ACC_BITS){1'b0}}, sum_im, sum_re};
  end else begin : g_out_full
    assign out_tdata = {sum_im, sum_re};
  end

endmodule

FILE: sv/cfir_checker.sv
// Port-level checks for the complex FIR filter, bound to the top level.
`timescale 1ns / 1ps

module cfir_checker #(
  parameter int TAPS        = cfir_pkg::TAPS_DEF,
  parameter int SAMPLE_BITS = cfir_pkg::SAMPLE_BITS_DEF,
  parameter int ACC_BITS    = cfir_pkg::ACC_BITS_DEF
) (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_tvalid,
  input logic                                  in_tready,
  input logic [((($clog2(TAPS)+2*SAMPLE_BITS)+7)/8)*8-1:0] in_tdata,
  input logic                                  in_tuser,
  input logic                                  out_tvalid,
  input logic                                  out_tready,
  input logic [((2*ACC_BITS+7)/8)*8-1:0]       out_tdata
);

  // A result that is not taken stays, unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // No transfer is taken in while a result waits on the output.
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |-> !in_tready)
    else $error("input taken during output stall");

  // With the output empty or draining, the input is open.
  a_ready_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid || out_tready |-> in_tready)
    else $error("input blocked without output stall");

  // Reset empties the result pipeline.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind complex_fir_filter cfir_checker #(
  .TAPS        (TAPS),
  .SAMPLE_BITS (SAMPLE_BITS),
  .ACC_BITS    (ACC_BITS)
) u_cfir_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tdata   (in_tdata),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: verif/tb.sv
// Self-checking testbench for the complex FIR filter stream block.
`timescale 1ns / 1ps

module tb;

  localparam int TAPS    = cfir_pkg::TAPS_DEF;
  localparam int SBITS   = cfir_pkg::SAMPLE_BITS_DEF;
  localparam int ABITS   = cfir_pkg::ACC_BITS_DEF;
  localparam int IDX_W   = $clog2(TAPS);
  localparam int IN_W    = (((IDX_W + 2*SBITS) + 7) / 8) * 8;
  localparam int OUT_W   = ((2*ABITS + 7) / 8) * 8;
  // Shift stage, multiply stage, one stage per adder-tree level.
  localparam int LATENCY = $clog2(TAPS) + 2;
  // Cycles without any transfer before the run is declared hung.
  localparam int QUIET_LIMIT = 5000;
  // Length of the forced output hold-off.
  localparam int HOLD_CYCLES = 200;

  typedef logic signed [SBITS-1:0] sample_t;
  typedef struct {
    logic [ABITS-1:0] re;
    logic [ABITS-1:0] im;
  } filter_out_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_tvalid = 1'b0;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata = '0;
  logic             in_tuser = 1'b0;
  logic             out_tvalid;
  logic             out_tready = 1'b0;
  logic [OUT_W-1:0] out_tdata;

  complex_fir_filter #(
    .TAPS(TAPS),
    .SAMPLE_BITS(SBITS),
    .ACC_BITS(ABITS)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata)
  );

  // 8 ns period: 4 ns high, 4 ns low.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Shadow copy of the filter state, updated on every input transfer.
  sample_t     shadow_dly_re [TAPS];
  sample_t     shadow_dly_im [TAPS];
  sample_t     shadow_coef_re [TAPS];
  sample_t     shadow_coef_im [TAPS];
  filter_out_t pending_outputs[$];

  int error_count = 0;
  int load_count = 0;
  int sample_count = 0;
  int result_count = 0;
  int stall_seen = 0;

  // Idle knobs for the two sides, in percent of cycles.
  int send_idle_pct = 0;
  int ready_stall_pct = 0;
  // Hold-off handshake between the test sequence and the receiver process.
  int hold_requests = 0;
  int hold_served = 0;

  initial begin
    for (int t = 0; t < TAPS; t++) begin
      shadow_dly_re[t] = '0;
      shadow_dly_im[t] = '0;
      shadow_coef_re[t] = '0;
      shadow_coef_im[t] = '0;
    end
  end

  // Apply one accepted item to the shadow state; a sample produces the complex
  // dot product of the delay line with the coefficients, wrapped to ABITS.
  task automatic filter_response(cfir_pkg::cmd_t cmd, logic [IDX_W-1:0] tap, sample_t re,
                                 sample_t im);
    longint      acc_re;
    longint      acc_im;
    filter_out_t res;
    acc_re = 0;
    acc_im = 0;
    if (cmd == cfir_pkg::CMD_LOAD) begin
      shadow_coef_re[tap] = re;
      shadow_coef_im[tap] = im;
      load_count++;
    end else begin
      for (int t = TAPS - 1; t >= 1; t--) begin
        shadow_dly_re[t] = shadow_dly_re[t-1];
        shadow_dly_im[t] = shadow_dly_im[t-1];
      end
      shadow_dly_re[0] = re;
      shadow_dly_im[0] = im;
      for (int t = 0; t < TAPS; t++) begin
        acc_re += longint'(shadow_dly_re[t]) * longint'(shadow_coef_re[t])
                - longint'(shadow_dly_im[t]) * longint'(shadow_coef_im[t]);
        acc_im += longint'(shadow_dly_re[t]) * longint'(shadow_coef_im[t])
                + longint'(shadow_coef_re[t]) * longint'(shadow_dly_im[t]);
      end
      res.re = acc_re[ABITS-1:0];
      res.im = acc_im[ABITS-1:0];
      pending_outputs.push_back(res);
      sample_count++;
    end
  endtask

  task automatic report_mismatch(string what, logic [ABITS-1:0] want,
                                 logic [ABITS-1:0] got);
    $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
    error_count++;
  endtask

  // Drive one item at the falling edge, hold it until the transfer happens,
  // then feed it to the predictor. Random idle cycles come first.
  task automatic send_item(cfir_pkg::cmd_t cmd, logic [IDX_W-1:0] tap, sample_t re,
                           sample_t im);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {{(IN_W - IDX_W - 2*SBITS){1'b0}}, im, re, tap};
    do begin
      @(posedge clk);
      if (!in_tready) stall_seen++;
    end while (!in_tready);
    filter_response(cmd, tap, re, im);
  endtask

  // Mostly random words, with the extremes and small values mixed in.
  function automatic sample_t pick_value();
    case ($urandom_range(9))
      0:       return sample_t'(-32768);
      1:       return sample_t'(32767);
      2:       return '0;
      3:       return sample_t'($urandom_range(16)) - sample_t'(8);
      default: return sample_t'($urandom());
    endcase
  endfunction

  // Receiver: random stalls, plus a long forced hold-off when one is requested.
  always @(negedge clk) begin
    int hold_left;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= ready_stall_pct);
    end
  end

  // Compare every result transfer against the oldest pending prediction.
  always @(posedge clk) begin
    filter_out_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_outputs.size() == 0) begin
        report_mismatch("unexpected result", '0, out_tdata[ABITS-1:0]);
      end else begin
        want = pending_outputs.pop_front();
        if (out_tdata[ABITS-1:0] !== want.re)
          report_mismatch("out_real", want.re, out_tdata[ABITS-1:0]);
        if (out_tdata[2*ABITS-1:ABITS] !== want.im)
          report_mismatch("out_imag", want.im, out_tdata[2*ABITS-1:ABITS]);
        result_count++;
      end
    end
  end

  // Watchdog: end the run if no transfer happens on either side for too long.
  always @(posedge clk) begin
    int quiet;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t watchdog: no transfer for %0d cycles", $realtime, quiet);
        $display("[complex_fir_filter] ERROR");
        $finish;
      end
    end
  end

  // Every tap gets a coefficient before the first sample; the first four taps carry
  // the extreme corner pairs, the next four unit and zero values, the rest random words.
  task automatic test_coef_load_all();
    sample_t re;
    sample_t im;
    for (int t = 0; t < TAPS; t++) begin
      case (t)
        0:       begin re = sample_t'(-32768); im = sample_t'(-32768); end
        1:       begin re = sample_t'(32767);  im = sample_t'(32767);  end
        2:       begin re = sample_t'(-32768); im = sample_t'(32767);  end
        3:       begin re = sample_t'(32767);  im = sample_t'(-32768); end
        4:       begin re = sample_t'(1);      im = '0;                end
        5:       begin re = '0;                im = sample_t'(1);      end
        6:       begin re = sample_t'(-1);     im = sample_t'(-1);     end
        7:       begin re = '0;                im = '0;                end
        default: begin re = sample_t'($urandom()); im = sample_t'($urandom()); end
      endcase
      send_item(cfir_pkg::CMD_LOAD, IDX_W'(t), re, im);
    end
  endtask

  // Extreme samples walk through the delay line; one reload lands mid-stream.
  task automatic test_directed_samples();
    send_item(cfir_pkg::CMD_SAMPLE, '0, sample_t'(-32768), sample_t'(-32768));
    send_item(cfir_pkg::CMD_SAMPLE, '1, sample_t'(32767), sample_t'(32767));
    send_item(cfir_pkg::CMD_SAMPLE, '0, sample_t'(-32768), sample_t'(32767));
    send_item(cfir_pkg::CMD_SAMPLE, '0, '0, '0);
    send_item(cfir_pkg::CMD_LOAD, '0, sample_t'(32767), sample_t'(-1));
    send_item(cfir_pkg::CMD_SAMPLE, '0, sample_t'(1), sample_t'(-1));
    send_item(cfir_pkg::CMD_SAMPLE, '0, sample_t'(32767), sample_t'(-32768));
  endtask

  // Random sample stream with occasional coefficient reloads, under the given
  // idle mix for both sides.
  task automatic test_random_traffic(int n, int idle_pct, int stall_pct);
    send_idle_pct = idle_pct;
    ready_stall_pct = stall_pct;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(9) == 0)
        send_item(cfir_pkg::CMD_LOAD, IDX_W'($urandom()), pick_value(), pick_value());
      else
        send_item(cfir_pkg::CMD_SAMPLE, IDX_W'($urandom()), pick_value(), pick_value());
    end
  endtask

  // Hold the output off for a long stretch while the sender keeps offering,
  // so the pipeline fills and in_tready drops.
  task automatic test_output_backpressure();
    send_idle_pct = 0;
    ready_stall_pct = 0;
    @(negedge clk);
    hold_requests++;
    for (int i = 0; i < 60; i++)
      send_item(cfir_pkg::CMD_SAMPLE, IDX_W'($urandom()), pick_value(), pick_value());
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_coef_load_all();
    test_directed_samples();
    test_random_traffic(210, 0, 0);
    test_random_traffic(210, 88, 0);
    test_random_traffic(210, 0, 88);
    test_random_traffic(210, 28, 28);
    test_output_backpressure();

    @(negedge clk);
    in_tvalid <= 1'b0;
    ready_stall_pct = 0;
    // Drain: the watchdog catches a result that never shows up.
    while (pending_outputs.size() != 0) @(posedge clk);
    repeat (4 * LATENCY) @(posedge clk);

    $display("Run covered %0d coefficient loads and %0d samples, %0d results checked.",
             load_count, sample_count, result_count);
    $display("Idle mixes on both sides plus a long output hold-off (%0d input stalls).",
             stall_seen);
    if (error_count == 0) begin
      $display("[complex_fir_filter] OK");
    end else begin
      $display("%0d mismatches", error_count);
      $display("[complex_fir_filter] ERROR");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/cfir_pkg.sv
sv/cfir_cell.sv
sv/cfir_add_tree.sv
sv/complex_fir_filter.sv
sv/cfir_checker.sv
verif/tb.sv
